// File: hw/rtl/mgw_pkg.sv
package mgw_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_ANTS   = 16;
	localparam int STEP_LIMIT = 64;

	localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int COORD_W  = $clog2(MAX_DIM);
	localparam int LIM_W    = COORD_W + 1;
	localparam int ANT_W    = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;

	localparam int GRID_BITS = MAX_WIDTH * MAX_HEIGHT;
	localparam int BADDR_W   = $clog2(GRID_BITS);
	localparam int WORD_W    = 64;
	localparam int OFF_W     = $clog2(WORD_W);
	localparam int WORDS     = (GRID_BITS + WORD_W - 1) / WORD_W;
	localparam int WADDR_W   = $clog2(WORDS);

	typedef struct packed {
		logic               go;
		logic [BADDR_W-1:0] bit_addr;
	} grid_req_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic was_set;
	} grid_rsp_t;

endpackage

// File: hw/rtl/mgw_rem_unit.sv
module mgw_rem_unit
	import mgw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] dividend,
	input  logic [LIM_W-1:0]   divisor,
	output logic               done,
	output logic [COORD_W-1:0] rem
);

	localparam int CNT_W = $clog2(COORD_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] dvd_q;
	logic [LIM_W-1:0]   dvs_q;
	logic [COORD_W-1:0] rem_q;
	logic [LIM_W-1:0]   trial;
	logic [LIM_W-1:0]   next_rem;

	// shift in one dividend bit, subtract when it fits
	assign trial    = {rem_q, dvd_q[COORD_W-1]};
	assign next_rem = (trial >= dvs_q) ? (trial - dvs_q) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
			rem_q <= next_rem[COORD_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hw/rtl/mgw_grid_mem.sv
module mgw_grid_mem
	import mgw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  grid_req_t req,
	output grid_rsp_t rsp
);

	logic [WORD_W-1:0]  mem_q [WORDS];
	logic [WORD_W-1:0]  rd_data_q;
	logic               clearing_q;
	logic [WADDR_W-1:0] clr_q;
	logic               phase_q;
	logic [WADDR_W-1:0] addr_q;
	logic [OFF_W-1:0]   off_q;
	logic [WADDR_W-1:0] req_word;
	logic               wr_en;
	logic [WADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0]  wr_data;

	assign req_word = req.bit_addr[BADDR_W-1:OFF_W];
	assign wr_en    = clearing_q | phase_q;
	assign wr_addr  = clearing_q ? clr_q : addr_q;
	assign wr_data  = clearing_q ? '0 : (rd_data_q ^ (WORD_W'(1) << off_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			phase_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == WADDR_W'(WORDS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			phase_q <= req.go & ~clearing_q & ~phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			addr_q    <= req_word;
			off_q     <= req.bit_addr[OFF_W-1:0];
			rd_data_q <= mem_q[req_word];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign rsp.idle    = ~clearing_q & ~phase_q;
	assign rsp.done    = phase_q;
	assign rsp.was_set = rd_data_q[off_q];

endmodule

// File: hw/rtl/multi_ant_grid_walker.sv
// Multi-ant walker on a shared toroidal one-bit grid.
// Input channel (in_valid/in_ready): action 0 places ant ant_index at
// start_x/start_y/start_heading and gives no result; action 1 runs that ant
// for steps_per_run steps, one result per step on the output channel
// (out_valid/out_ready), the final one flagged by last. Items for an ant at or
// above the number of active ants, and places outside the grid, give nothing.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 grid_width,
// 1 grid_height, 2 steps_per_run, 3 active ant total; write only while idle.
// A run item first reduces the column and row modulo the grid size in a
// shared bit-serial remainder unit, then for each step does a
// read-modify-write of the grid memory (64-bit words, one port each way).
// in_ready is low while a request is in work.
// Reset: registers go to 1024, 768, 25, 5, ants to zero, and the grid is
// cleared one word per cycle, all 16384 words, with in_ready held low.
// A stalled receiver holds the result register and the step sequencer waits.
module multi_ant_grid_walker
	import mgw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [3:0]  ant_index,
	input  logic [9:0]  start_x,
	input  logic [9:0]  start_y,
	input  logic [1:0]  start_heading,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  mover,
	output logic [9:0]  pixel_x,
	output logic [9:0]  pixel_y,
	output logic        pixel_on,
	output logic        last
);

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STEPS  = 2'd2;
	localparam logic [1:0] REG_ANTS   = 2'd3;

	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_RUN   = 1'b1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MODX = 3'd1;
	localparam logic [2:0] S_MODY = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [6:0]  steps_q;
	logic [4:0]  ants_q;

	logic [COORD_W-1:0] col_q [MAX_ANTS];
	logic [COORD_W-1:0] row_q [MAX_ANTS];
	logic [1:0]         head_q [MAX_ANTS];

	logic [2:0]         state_q;
	logic [ANT_W-1:0]   idx_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [1:0]         hd_q;
	logic [5:0]         k_q;
	logic               set_q;

	logic               out_valid_q;
	logic [3:0]         mover_q;
	logic [9:0]         px_q;
	logic [9:0]         py_q;
	logic               on_q;
	logic               last_q;

	logic [LIM_W-1:0]   eff_w;
	logic [LIM_W-1:0]   eff_h;
	logic [6:0]         eff_steps;
	logic [4:0]         eff_ants;
	logic [ANT_W-1:0]   in_idx;
	logic               in_acc;
	logic               idx_ok;
	logic               place_ok;

	logic               rem_start;
	logic [COORD_W-1:0] rem_dvd;
	logic [LIM_W-1:0]   rem_dvs;
	logic               rem_done;
	logic [COORD_W-1:0] rem_val;

	grid_req_t          greq;
	grid_rsp_t          grsp;

	logic               out_free;
	logic               emit_set;
	logic               emit_now;
	logic               step_last;
	logic               mv_pos_x;
	logic               mv_neg_x;
	logic               mv_pos_y;
	logic               mv_neg_y;
	logic [COORD_W-1:0] nx;
	logic [COORD_W-1:0] ny;
	logic [1:0]         nh;

	always_comb begin
		if (width_q == '0) begin
			eff_w = LIM_W'(1);
		end else if (width_q > 11'(MAX_WIDTH)) begin
			eff_w = LIM_W'(MAX_WIDTH);
		end else begin
			eff_w = LIM_W'(width_q);
		end
		if (height_q == '0) begin
			eff_h = LIM_W'(1);
		end else if (height_q > 11'(MAX_HEIGHT)) begin
			eff_h = LIM_W'(MAX_HEIGHT);
		end else begin
			eff_h = LIM_W'(height_q);
		end
		if (steps_q == '0) begin
			eff_steps = 7'd1;
		end else if (steps_q > 7'(STEP_LIMIT)) begin
			eff_steps = 7'(STEP_LIMIT);
		end else begin
			eff_steps = steps_q;
		end
		eff_ants = (ants_q > 5'(MAX_ANTS)) ? 5'(MAX_ANTS) : ants_q;
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) & grsp.idle;
	assign in_acc    = in_valid & in_ready;
	assign in_idx    = ANT_W'(ant_index);
	assign idx_ok    = {1'b0, ant_index} < eff_ants;
	assign place_ok  = (LIM_W'(start_x) < eff_w) & (LIM_W'(start_y) < eff_h);

	assign rem_start = (in_acc & idx_ok & (action == ACT_RUN)) |
	                   ((state_q == S_MODX) & rem_done);
	assign rem_dvd   = (state_q == S_IDLE) ? col_q[in_idx] : y_q;
	assign rem_dvs   = (state_q == S_IDLE) ? eff_w : eff_h;

	mgw_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dvd),
		.divisor  (rem_dvs),
		.done     (rem_done),
		.rem      (rem_val)
	);

	assign greq.go       = (state_q == S_RD);
	assign greq.bit_addr = BADDR_W'(y_q) * BADDR_W'(MAX_WIDTH) + BADDR_W'(x_q);

	mgw_grid_mem u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (greq),
		.rsp    (grsp)
	);

	assign out_free  = ~out_valid_q | out_ready;
	assign emit_set  = (state_q == S_WAIT) ? grsp.was_set : set_q;
	assign emit_now  = (((state_q == S_WAIT) & grsp.done) | (state_q == S_EMIT)) & out_free;
	assign step_last = {1'b0, k_q} == (eff_steps - 7'd1);

	assign mv_pos_x = ((hd_q == 2'd0) & emit_set) | ((hd_q == 2'd2) & ~emit_set);
	assign mv_neg_x = ((hd_q == 2'd0) & ~emit_set) | ((hd_q == 2'd2) & emit_set);
	assign mv_pos_y = ((hd_q == 2'd1) & emit_set) | ((hd_q == 2'd3) & ~emit_set);
	assign mv_neg_y = ((hd_q == 2'd1) & ~emit_set) | ((hd_q == 2'd3) & emit_set);

	always_comb begin
		nx = x_q;
		if (mv_pos_x) begin
			nx = (LIM_W'(x_q) + 1'b1 >= eff_w) ? '0 : x_q + 1'b1;
		end else if (mv_neg_x) begin
			nx = (x_q == '0) ? COORD_W'(eff_w - 1'b1) : x_q - 1'b1;
		end
		ny = y_q;
		if (mv_pos_y) begin
			ny = (LIM_W'(y_q) + 1'b1 >= eff_h) ? '0 : y_q + 1'b1;
		end else if (mv_neg_y) begin
			ny = (y_q == '0) ? COORD_W'(eff_h - 1'b1) : y_q - 1'b1;
		end
		nh = emit_set ? hd_q + 2'd1 : hd_q - 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 11'd768;
			steps_q  <= 7'd25;
			ants_q   <= 5'd5;
		end else if (cfg_valid & cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_STEPS:  steps_q  <= cfg_data[6:0];
				REG_ANTS:   ants_q   <= cfg_data[4:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < MAX_ANTS; i++) begin
				col_q[i]  <= '0;
				row_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc & idx_ok) begin
						if (action == ACT_PLACE) begin
							if (place_ok) begin
								col_q[in_idx]  <= COORD_W'(start_x);
								row_q[in_idx]  <= COORD_W'(start_y);
								head_q[in_idx] <= start_heading;
							end
						end else begin
							state_q <= S_MODX;
						end
					end
				end
				S_MODX: begin
					if (rem_done) begin
						state_q <= S_MODY;
					end
				end
				S_MODY: begin
					if (rem_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WAIT;
				end
				S_WAIT, S_EMIT: begin
					if (emit_now) begin
						if (step_last) begin
							state_q        <= S_IDLE;
							col_q[idx_q]  <= nx;
							row_q[idx_q]  <= ny;
							head_q[idx_q] <= nh;
						end else begin
							state_q <= S_RD;
						end
					end else if (state_q == S_WAIT && grsp.done) begin
						state_q <= S_EMIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q <= in_idx;
			x_q   <= col_q[in_idx];
			y_q   <= row_q[in_idx];
			hd_q  <= head_q[in_idx];
			k_q   <= '0;
		end
		if (state_q == S_MODX && rem_done) begin
			x_q <= rem_val;
		end
		if (state_q == S_MODY && rem_done) begin
			y_q <= rem_val;
		end
		if (state_q == S_WAIT && grsp.done) begin
			set_q <= grsp.was_set;
		end
		if (emit_now) begin
			x_q     <= nx;
			y_q     <= ny;
			hd_q    <= nh;
			k_q     <= k_q + 1'b1;
			mover_q <= 4'(idx_q);
			px_q    <= 10'(x_q);
			py_q    <= 10'(y_q);
			on_q    <= ~emit_set;
			last_q  <= step_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign mover     = mover_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign pixel_on  = on_q;
	assign last      = last_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mgw_pkg::*;

	localparam int SETTLE      = 200;
	localparam int HOLD_CYCLES = 600;

	typedef enum logic {ACT_PLACE = 1'b0, ACT_RUN = 1'b1} act_e;
	typedef enum logic [1:0] {REG_WIDTH, REG_HEIGHT, REG_STEPS, REG_ANTS} reg_e;
	typedef enum logic [1:0] {EAST, SOUTH, WEST, NORTH} heading_e;

	typedef struct packed {
		logic [ANT_W-1:0]   mover;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               lit;
		logic               last;
	} pixel_t;

	typedef struct {
		act_e               action;
		logic [ANT_W-1:0]   idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		heading_e           hd;
		bit                 pin;
		logic [COORD_W-1:0] pin_x;
		logic [COORD_W-1:0] pin_y;
		bit                 pin_lit;
	} walk_req_t;

	typedef struct {
		logic [10:0] cols;
		logic [10:0] rows;
		logic [10:0] steps;
		logic [10:0] ants;
		int          items;
		bit          calm;
		bit          hold;
	} stage_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [3:0]  ant_index;
	logic [9:0]  start_x;
	logic [9:0]  start_y;
	logic [1:0]  start_heading;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  mover;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic        pixel_on;
	logic        last;

	multi_ant_grid_walker u_top (.*);

	bit                 shadow_grid [MAX_WIDTH * MAX_HEIGHT];
	logic [COORD_W-1:0] shadow_col [MAX_ANTS];
	logic [COORD_W-1:0] shadow_row [MAX_ANTS];
	heading_e           shadow_heading [MAX_ANTS];
	logic [10:0]        cols_reg  = 11'd1024;
	logic [10:0]        rows_reg  = 11'd768;
	logic [6:0]         steps_reg = 7'd25;
	logic [4:0]         ants_reg  = 5'd5;

	pixel_t pending_pixels [$];
	int     mismatch_count = 0;
	bit     calm = 1'b0;
	bit     hold_req = 1'b0;
	bit     hold_served = 1'b0;

	walk_req_t opening_plan [20] = '{
		'{ACT_RUN,   4'd0,  10'd0,    10'd0,    EAST,  1'b1, 10'd0,   10'd0,   1'b1},
		'{ACT_PLACE, 4'd2,  10'd500,  10'd400,  SOUTH, 1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd2,  10'd0,    10'd0,    EAST,  1'b1, 10'd500, 10'd400, 1'b1},
		'{ACT_RUN,   4'd2,  10'd1023, 10'd1023, NORTH, 1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_PLACE, 4'd1,  10'd1023, 10'd767,  NORTH, 1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd1,  10'd1023, 10'd1023, WEST,  1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_PLACE, 4'd3,  10'd1023, 10'd768,  WEST,  1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_PLACE, 4'd3,  10'd0,    10'd1023, EAST,  1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd3,  10'd0,    10'd0,    EAST,  1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd5,  10'd0,    10'd0,    EAST,  1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd15, 10'd1023, 10'd1023, NORTH, 1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_PLACE, 4'd15, 10'd5,    10'd5,    SOUTH, 1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_PLACE, 4'd0,  10'd300,  10'd300,  WEST,  1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd0,  10'd0,    10'd0,    EAST,  1'b1, 10'd300, 10'd300, 1'b1},
		'{ACT_PLACE, 4'd4,  10'd700,  10'd0,    NORTH, 1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd4,  10'd0,    10'd0,    EAST,  1'b1, 10'd700, 10'd0,   1'b1},
		'{ACT_PLACE, 4'd3,  10'd600,  10'd600,  NORTH, 1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd3,  10'd0,    10'd0,    EAST,  1'b1, 10'd600, 10'd600, 1'b1},
		'{ACT_RUN,   4'd3,  10'd0,    10'd0,    EAST,  1'b0, 10'd0,   10'd0,   1'b0},
		'{ACT_RUN,   4'd4,  10'd0,    10'd0,    EAST,  1'b0, 10'd0,   10'd0,   1'b0}
	};

	stage_t stages [9] = '{
		'{11'd1024, 11'd1024, 11'd64,   11'd16,   40, 1'b0, 1'b0},
		'{11'd5,    11'd3,    11'd9,    11'd16,   50, 1'b0, 1'b0},
		'{11'd1,    11'd1,    11'd1,    11'd1,    30, 1'b0, 1'b0},
		'{11'd0,    11'd0,    11'd0,    11'd0,    8,  1'b0, 1'b0},
		'{11'd2047, 11'd2047, 11'd2047, 11'd2047, 30, 1'b0, 1'b0},
		'{11'd8,    11'd6,    11'd7,    11'd3,    80, 1'b1, 1'b0},
		'{11'd16,   11'd16,   11'd12,   11'd16,   80, 1'b0, 1'b1},
		'{11'd2,    11'd2,    11'd3,    11'd2,    60, 1'b0, 1'b0},
		'{11'd37,   11'd23,   11'd65,   11'd9,    60, 1'b0, 1'b0}
	};

	function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [COORD_W-1:0] step_coord(input int unsigned p, input int d,
			input int unsigned lim);
		if (d > 0)
			return (p + 1 >= lim) ? '0 : COORD_W'(p + 1);
		else if (d < 0)
			return (p == 0) ? COORD_W'(lim - 1) : COORD_W'(p - 1);
		return COORD_W'(p);
	endfunction

	function automatic void walk_ant(input logic [ANT_W-1:0] idx);
		int unsigned w, h, n, x, y, spot;
		int          dx, dy, turn;
		heading_e    hd;
		logic [1:0]  next_hd;
		bit          was_set;
		pixel_t      px;
		w = clamp(cols_reg, 1, MAX_WIDTH);
		h = clamp(rows_reg, 1, MAX_HEIGHT);
		n = clamp(steps_reg, 1, STEP_LIMIT);
		for (int k = 0; k < n; k++) begin
			x = shadow_col[idx] % w;
			y = shadow_row[idx] % h;
			hd = shadow_heading[idx];
			spot = y * MAX_WIDTH + x;
			was_set = shadow_grid[spot];
			shadow_grid[spot] = !was_set;
			turn = was_set ? 1 : -1;
			dx = 0;
			dy = 0;
			case (hd)
				EAST:    dx = 1;
				SOUTH:   dy = 1;
				WEST:    dx = -1;
				default: dy = -1;
			endcase
			shadow_col[idx] = step_coord(x, dx * turn, w);
			shadow_row[idx] = step_coord(y, dy * turn, h);
			next_hd = hd + (was_set ? 2'd1 : 2'd3);
			shadow_heading[idx] = heading_e'(next_hd);
			px.mover = idx;
			px.x = COORD_W'(x);
			px.y = COORD_W'(y);
			px.lit = !was_set;
			px.last = (k == n - 1);
			pending_pixels.push_back(px);
		end
	endfunction

	function automatic bit apply_request(input walk_req_t r);
		int first;
		if (r.idx >= clamp(ants_reg, 0, MAX_ANTS))
			return 1'b0;
		if (r.action == ACT_PLACE) begin
			if (r.x >= clamp(cols_reg, 1, MAX_WIDTH) || r.y >= clamp(rows_reg, 1, MAX_HEIGHT))
				return 1'b0;
			shadow_col[r.idx] = r.x;
			shadow_row[r.idx] = r.y;
			shadow_heading[r.idx] = r.hd;
			return 1'b1;
		end
		first = pending_pixels.size();
		walk_ant(r.idx);
		if (r.pin)
			pending_pixels[first] = '{r.idx, r.pin_x, r.pin_y, r.pin_lit, 1'b0};
		return 1'b1;
	endfunction

	function automatic walk_req_t random_request();
		walk_req_t   r;
		int unsigned pick, ants;
		ants = clamp(ants_reg, 0, MAX_ANTS);
		pick = $urandom_range(0, 99);
		r.action = act_e'($urandom_range(0, 1));
		r.idx = ANT_W'($urandom_range(0, 15));
		r.x = COORD_W'($urandom_range(0, 1023));
		r.y = COORD_W'($urandom_range(0, 1023));
		r.hd = heading_e'($urandom_range(0, 3));
		r.pin = 1'b0;
		r.pin_x = '0;
		r.pin_y = '0;
		r.pin_lit = 1'b0;
		if (ants != 0 && pick < 90) begin
			r.idx = ANT_W'($urandom_range(0, ants - 1));
			if (pick < 60) begin
				r.action = ACT_RUN;
			end else begin
				r.action = ACT_PLACE;
				if (pick < 82) begin
					r.x = COORD_W'($urandom_range(0, clamp(cols_reg, 1, MAX_WIDTH) - 1));
					r.y = COORD_W'($urandom_range(0, clamp(rows_reg, 1, MAX_HEIGHT) - 1));
				end
			end
		end
		return r;
	endfunction

	task automatic offer(input walk_req_t r, output bit useful);
		in_valid <= 1'b1;
		action <= r.action;
		ant_index <= r.idx;
		start_x <= r.x;
		start_y <= r.y;
		start_heading <= r.hd;
		do @(posedge clk); while (in_ready !== 1'b1);
		useful = apply_request(r);
	endtask

	task automatic idle_gap();
		if (!calm && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 30);
		end
	endtask

	task automatic settle_all(input int extra);
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input reg_e which, input logic [10:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (which)
			REG_WIDTH:  cols_reg = value;
			REG_HEIGHT: rows_reg = value;
			REG_STEPS:  steps_reg = value[6:0];
			default:    ants_reg = value[4:0];
		endcase
	endtask

	task automatic check_field(input string what, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	task automatic match_pixel();
		pixel_t want;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected pixel mover %0d x %0d y %0d on %0b last %0b",
				$time, mover, pixel_x, pixel_y, pixel_on, last);
			mismatch_count++;
		end else begin
			want = pending_pixels.pop_front();
			check_field("mover", want.mover, mover);
			check_field("pixel_x", want.x, pixel_x);
			check_field("pixel_y", want.y, pixel_y);
			check_field("pixel_on", want.lit, pixel_on);
			check_field("last", want.last, last);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("** multi_ant_grid_walker: FAILED **");
		$finish;
	end

	initial begin : result_side
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				match_pixel();
			if (hold_req && !hold_served) begin
				stall_left = HOLD_CYCLES;
				hold_served = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 30);
			end
		end
	end

	initial begin : request_side
		bit useful;
		int made, tries;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= ACT_PLACE;
		ant_index <= '0;
		start_x <= '0;
		start_y <= '0;
		start_heading <= EAST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_plan[i]) begin
			offer(opening_plan[i], useful);
			idle_gap();
		end

		foreach (stages[s]) begin
			in_valid <= 1'b0;
			settle_all(SETTLE);
			calm = stages[s].calm;
			write_reg(REG_WIDTH, stages[s].cols);
			write_reg(REG_HEIGHT, stages[s].rows);
			write_reg(REG_STEPS, stages[s].steps);
			write_reg(REG_ANTS, stages[s].ants);
			cfg_valid <= 1'b0;
			made = 0;
			tries = 0;
			while (made < stages[s].items && tries < 3 * stages[s].items) begin
				if (stages[s].hold && tries == stages[s].items / 3)
					hold_req = 1'b1;
				if (stages[s].hold && tries == 2 * stages[s].items / 3) begin
					in_valid <= 1'b0;
					settle_all(0);
				end
				offer(random_request(), useful);
				if (useful)
					made++;
				tries++;
				idle_gap();
			end
		end

		in_valid <= 1'b0;
		settle_all(SETTLE);
		if (mismatch_count == 0)
			$display("** multi_ant_grid_walker: PASSED **");
		else
			$display("** multi_ant_grid_walker: FAILED **");
		$finish;
	end

endmodule
